@@ rtl/tpcp_pkg.sv @@
// Shared constants for the three-phase current regulator.
`default_nettype none
package tpcp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PWM_PERIOD   = 3'd0;
  localparam logic [2:0] CFG_KP_GAIN      = 3'd1;
  localparam logic [2:0] CFG_KI_GAIN      = 3'd2;
  localparam logic [2:0] CFG_INTEG_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_SETTLE_DELAY = 3'd4;
  localparam logic [2:0] CFG_CALIB_SAMPLES = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Register reset values
  localparam logic [15:0] PWM_PERIOD_RST   = 16'd1000;
  localparam logic [15:0] KP_GAIN_RST      = 16'd256;
  localparam logic [15:0] KI_GAIN_RST      = 16'd16;
  localparam logic [19:0] INTEG_LIMIT_RST  = 20'd32767;
  localparam logic [7:0]  SETTLE_DELAY_RST = 8'd4;
  localparam logic [15:0] CALIB_SAMPLES_RST = 16'd1000;

  // Item kinds carried on tuser
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_VOLT   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Duty clamp, Q15
  localparam logic [15:0] DUTY_MIN = 16'd3277;
  localparam logic [15:0] DUTY_MAX = 16'd29491;

  // ceil(2^30 / 100): exact floor(x/100) for x below 2^23
  localparam logic [23:0] CAL_RECIP = 24'd10737419;
  localparam int          CAL_SHIFT = 30;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

endpackage
`default_nettype wire

@@ rtl/three_phase_current_pi_pwm.sv @@
// Three-phase PWM current regulator: PI loop with integrator clamp, per-phase state in RAM.
//
// Input channel s_*: one beat per item. tuser is the kind (0 ADC sample, 1 current target,
// 2 direct voltage). Output channel m_*: one beat per new compare value for a phase.
// Configuration: cfg_we / cfg_index / cfg_data write a register at the clock edge; write
// only while the block is idle.
// Per-phase state (zero level, settle count, integrator, target, direction) sits in a
// RAM with registered read; an item is read, modified and written back before the next is
// taken, so accesses to one entry never overlap.
// Steps per accepted item: a sample that runs a PI update takes read, two gain multiplies,
// duty clamp, period multiply and write-back; a calibration sample or a direct voltage takes
// read, a multiply and write-back; a target or a sample that only counts down, read and
// write-back; an ignored item, read alone. Only a PI update or a voltage raises m_tvalid.
// Reset: synchronous; registers take their defaults, calibration restarts and every RAM
// entry reads as its reset value until written, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next item is still
// accepted and only waits at write-back if it too produces a result.
`default_nettype none
module three_phase_current_pi_pwm
  import tpcp_pkg::*;
#(
  parameter int PHASES   = 3,
  parameter int ADC_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [1:0] phase, [13:2] adc_sample, [14] counting_down, [30:15] target, [31] zero
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  // [1:0] kind
  input  wire logic [1:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [1:0] phase_out, [17:2] compare_value, [18] direction_negative, [23:19] zero
  output logic [M_TDATA_W-1:0]        m_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int ST_LO = ADC_BITS;
  localparam int IN_LO = ADC_BITS + 8;
  localparam int TG_LO = ADC_BITS + 32;
  localparam int DR_B  = ADC_BITS + 48;
  localparam int EW    = ADC_BITS + 49;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_CAL1 = 4'd2;
  localparam logic [3:0] ST_CAL2 = 4'd3;
  localparam logic [3:0] ST_PI1  = 4'd4;
  localparam logic [3:0] ST_PI2  = 4'd5;
  localparam logic [3:0] ST_PI3  = 4'd6;
  localparam logic [3:0] ST_CMP1 = 4'd7;
  localparam logic [3:0] ST_CMP2 = 4'd8;
  localparam logic [3:0] ST_WB   = 4'd9;

  localparam logic [EW-1:0] ENTRY_RST =
    {1'b1, 16'd0, 24'd0, SETTLE_DELAY_RST, {ADC_BITS{1'b0}}};

  // configuration
  logic [15:0] pwm_period;
  logic [15:0] kp_gain;
  logic [15:0] ki_gain;
  logic [19:0] integrator_limit;
  logic [7:0]  settle_delay;
  logic [15:0] calib_samples;

  // control
  logic [3:0]        state;
  logic [15:0]       calib_left;
  logic              current_mode;
  logic [PHASES-1:0] ent_valid;

  // item
  logic [1:0]          it_kind;
  logic [1:0]          it_phase;
  logic [AW-1:0]       it_addr;
  logic [ADC_BITS-1:0] it_sample;
  logic                it_down;
  logic signed [15:0]  it_target;

  // working copy of the entry
  logic [ADC_BITS-1:0] w_zero;
  logic [7:0]          w_settle;
  logic signed [23:0]  w_integ;
  logic signed [15:0]  w_target;
  logic                w_dir;

  // datapath
  logic signed [18:0] err;
  logic [22:0]        calx;
  logic [46:0]        calp;
  logic signed [35:0] ik;
  logic signed [35:0] pk;
  logic [15:0]        duty;
  logic [31:0]        cprod;
  logic [15:0]        res_cmp;
  logic               has_res;

  // output register
  logic        out_valid;
  logic [1:0]  out_phase;
  logic [15:0] out_cmp;
  logic        out_dir;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] rd_entry;

  logic [3:0]          s_phase_ext;
  logic [15:0]         s_sample_ext;
  logic                in_acc;
  logic                wb_go;
  logic                ph_ok;
  logic [ADC_BITS-1:0] e_zero;
  logic [7:0]          e_settle;
  logic signed [15:0]  e_target;
  logic                e_dir;
  logic [7:0]          settle_dec;
  logic signed [18:0]  err_c;
  logic [22:0]         calx_c;
  logic signed [25:0]  isum;
  logic signed [25:0]  ilim;
  logic signed [25:0]  vout;
  logic [25:0]         vmag;
  logic [16:0]         volt_mag;
  logic [16:0]         cmp_raw;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_dir, out_cmp, out_phase};

  assign s_phase_ext  = {2'b00, s_tdata[1:0]};
  assign s_sample_ext = {4'd0, s_tdata[13:2]};
  assign ram_raddr    = s_phase_ext[AW-1:0];

  assign rd_entry   = ent_valid[it_addr] ? ram_rdata : ENTRY_RST;
  assign e_zero     = rd_entry[ADC_BITS-1:0];
  assign e_settle   = rd_entry[ST_LO +: 8];
  assign e_target   = rd_entry[TG_LO +: 16];
  assign e_dir      = rd_entry[DR_B];
  assign settle_dec = e_settle - 8'd1;
  assign ph_ok      = 32'(it_phase) < PHASES;

  assign err_c = {{3{e_target[15]}}, e_target}
               - ({{(19 - ADC_BITS){1'b0}}, it_sample} - {{(19 - ADC_BITS){1'b0}}, e_zero});
  assign calx_c = 23'(it_sample) * 23'd5 + 23'(e_zero) * 23'd95;

  assign ilim = $signed({6'd0, integrator_limit});
  assign isum = {{2{w_integ[23]}}, w_integ} + {{2{ik[35]}}, ik[35:12]};
  assign vout = {{2{pk[35]}}, pk[35:12]} + {{2{w_integ[23]}}, w_integ};
  assign vmag = vout[25] ? 26'(-vout) : 26'(vout);
  assign volt_mag = it_target[15] ? 17'(-{it_target[15], it_target}) : {1'b0, it_target};
  // duty never exceeds 1.0 in Q15, so the product is at most one period
  assign cmp_raw = cprod[31:15];

  assign wb_go     = !has_res || !out_valid || m_tready;
  assign ram_we    = (state == ST_WB) && wb_go;
  assign ram_wdata = {w_dir, w_target, w_integ, w_settle, w_zero};

  tpcp_ram #(
    .WIDTH (EW),
    .DEPTH (PHASES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period       <= PWM_PERIOD_RST;
      kp_gain          <= KP_GAIN_RST;
      ki_gain          <= KI_GAIN_RST;
      integrator_limit <= INTEG_LIMIT_RST;
      settle_delay     <= SETTLE_DELAY_RST;
      calib_samples    <= CALIB_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWM_PERIOD:    pwm_period       <= cfg_data[15:0];
        CFG_KP_GAIN:       kp_gain          <= cfg_data[15:0];
        CFG_KI_GAIN:       ki_gain          <= cfg_data[15:0];
        CFG_INTEG_LIMIT:   integrator_limit <= cfg_data;
        CFG_SETTLE_DELAY:  settle_delay     <= cfg_data[7:0];
        CFG_CALIB_SAMPLES: calib_samples    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      calib_left   <= CALIB_SAMPLES_RST;
      current_mode <= 1'b0;
      ent_valid    <= '0;
      out_valid    <= 1'b0;
    end else begin
      // a new result may replace the beat leaving in the same cycle
      if (state == ST_WB && wb_go && has_res) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (!ph_ok || it_kind == KIND_NONE) begin
            state <= ST_IDLE;
          end else begin
            unique case (it_kind)
              KIND_SAMPLE: begin
                if (calib_left != 16'd0) begin
                  calib_left <= calib_left - 16'd1;
                  state      <= ST_CAL1;
                end else if (!current_mode || !(it_down ^ e_dir)) begin
                  state <= ST_IDLE;
                end else if (settle_dec != 8'd0) begin
                  state <= ST_WB;
                end else begin
                  state <= ST_PI1;
                end
              end
              KIND_TARGET: begin
                current_mode <= 1'b1;
                state        <= ST_WB;
              end
              KIND_VOLT: begin
                if (calib_left != 16'd0) begin
                  state <= ST_IDLE;
                end else begin
                  current_mode <= 1'b0;
                  state        <= ST_CMP1;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CAL1: state <= ST_CAL2;
        ST_CAL2: state <= ST_WB;
        ST_PI1:  state <= ST_PI2;
        ST_PI2:  state <= ST_PI3;
        ST_PI3:  state <= ST_CMP1;
        ST_CMP1: state <= ST_CMP2;
        ST_CMP2: state <= ST_WB;
        ST_WB: begin
          if (wb_go) begin
            ent_valid[it_addr] <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          it_kind   <= s_tuser;
          it_phase  <= s_tdata[1:0];
          it_addr   <= s_phase_ext[AW-1:0];
          it_sample <= s_sample_ext[ADC_BITS-1:0];
          it_down   <= s_tdata[14];
          it_target <= s_tdata[30:15];
        end
      end
      ST_RD: begin
        w_zero   <= e_zero;
        w_integ  <= rd_entry[IN_LO +: 24];
        calx     <= calx_c;
        err      <= err_c;
        // settle count moves only on samples past calibration; reload on reaching zero
        w_settle <= (it_kind == KIND_SAMPLE && calib_left == 16'd0)
                  ? ((settle_dec == 8'd0) ? settle_delay : settle_dec) : e_settle;
        w_target <= (it_kind == KIND_TARGET) ? it_target : e_target;
        w_dir    <= (it_kind == KIND_VOLT) ? !it_target[15] : e_dir;
        has_res  <= (it_kind == KIND_VOLT);
        if (it_kind == KIND_VOLT) begin
          duty <= volt_mag[15:0];
        end
      end
      ST_CAL1: calp <= 47'(calx) * 47'(CAL_RECIP);
      ST_CAL2: w_zero <= calp[CAL_SHIFT +: ADC_BITS];
      ST_PI1:  ik <= $signed({1'b0, ki_gain}) * err;
      ST_PI2: begin
        pk <= $signed({1'b0, kp_gain}) * err;
        if (isum > ilim) begin
          w_integ <= ilim[23:0];
        end else if (isum < -ilim) begin
          w_integ <= 24'(-ilim);
        end else begin
          w_integ <= isum[23:0];
        end
      end
      ST_PI3: begin
        if (vmag < 26'(DUTY_MIN)) begin
          duty <= DUTY_MIN;
        end else if (vmag > 26'(DUTY_MAX)) begin
          duty <= DUTY_MAX;
        end else begin
          duty <= vmag[15:0];
        end
        w_dir   <= !w_target[15];
        has_res <= 1'b1;
      end
      ST_CMP1: cprod <= 32'(duty) * 32'(pwm_period);
      ST_CMP2: res_cmp <= (cmp_raw == {1'b0, pwm_period}) ? 16'd0 : cmp_raw[15:0];
      ST_WB: begin
        if (wb_go && has_res) begin
          out_phase <= it_phase;
          out_cmp   <= res_cmp;
          out_dir   <= !w_dir;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/tpcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tpcp_chk.sv @@
// Port-level checker for the current regulator, bound to the top level.
`default_nettype none
module tpcp_chk
  import tpcp_pkg::*;
#(
  parameter int PHASES = 3
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // output register empties on reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat present after reset");

  // one item in flight: no input beat right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  // a result needs the read and write-back cycles, never the next edge
  a_no_fast_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared one cycle after input beat");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[1:0]) < PHASES && m_tdata[M_TDATA_W-1:19] == '0))
    else $error("output phase out of range or pad bits set");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output beat changed");

endmodule

bind three_phase_current_pi_pwm tpcp_chk #(.PHASES(PHASES)) u_tpcp_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/three_phase_current_pi_pwm_tb.sv @@
// Self-checking testbench for the three-phase current regulator: stream stimulus, predictor, scoreboard.
`timescale 1ns / 100ps
module three_phase_current_pi_pwm_tb;
  import tpcp_pkg::*;

  localparam int NPH = 3;
  localparam int HOLD_OFF = 16;            // cycles allowed after the last result before a write
  localparam int RUN_LIMIT_NS = 6_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  phase;
    logic [11:0] sample;
    logic        down;
    logic [15:0] target;
  } stim_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] cmp;
    logic        neg;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  three_phase_current_pi_pwm uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stim_t   item_q[$];
  update_t update_q[$];
  int errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic in_fire = 1'b0;

  // register shadows
  logic [15:0] per_reg, kp_reg, ki_reg, calib_reg;
  logic [19:0] lim_reg;
  logic [7:0]  settle_reg;

  // predicted block state
  logic [15:0] cal_remaining;
  logic [11:0] zero_lvl[NPH];
  logic [7:0]  settle_cnt[NPH];
  int          integ_acc[NPH];
  logic [15:0] target_cur[NPH];
  bit          dir_up[NPH];
  bit          loop_on;

  initial forever #4 clk = ~clk;

  function automatic logic [15:0] scale_to_period(input int duty);
    longint prod;
    if (per_reg == 16'd0) return 16'd0;
    prod = (longint'(duty) * longint'(per_reg)) >> 15;
    return 16'(prod % longint'(per_reg));
  endfunction

  task automatic regulate(input stim_t it, output bit fires, output update_t res);
    int ph;
    int t;
    longint err, integ, vout, lim;
    ph = it.phase;
    fires = 1'b0;
    res = '0;
    if (ph < NPH) begin
      case (it.kind)
        KIND_SAMPLE: begin
          if (cal_remaining != 16'd0) begin
            cal_remaining = cal_remaining - 16'd1;
            zero_lvl[ph] = 12'((5 * int'(it.sample) + 95 * int'(zero_lvl[ph])) / 100);
          end else if (loop_on && (it.down ^ dir_up[ph])) begin
            settle_cnt[ph] = settle_cnt[ph] - 8'd1;
            if (settle_cnt[ph] == 8'd0) begin
              settle_cnt[ph] = settle_reg;
              err = longint'($signed(target_cur[ph]))
                    - (longint'(it.sample) - longint'(zero_lvl[ph]));
              lim = longint'(lim_reg);
              integ = longint'(integ_acc[ph]) + ((longint'(ki_reg) * err) >>> 12);
              if (integ > lim) integ = lim;
              if (integ < -lim) integ = -lim;
              integ_acc[ph] = int'(integ);
              vout = ((longint'(kp_reg) * err) >>> 12) + integ;
              if (vout < 0) vout = -vout;
              if (vout < longint'(DUTY_MIN)) vout = longint'(DUTY_MIN);
              if (vout > longint'(DUTY_MAX)) vout = longint'(DUTY_MAX);
              dir_up[ph] = !target_cur[ph][15];
              res.phase = 2'(ph);
              res.cmp = scale_to_period(int'(vout));
              res.neg = !dir_up[ph];
              fires = 1'b1;
            end
          end
        end
        KIND_TARGET: begin
          target_cur[ph] = it.target;
          loop_on = 1'b1;
        end
        KIND_VOLT: begin
          if (cal_remaining == 16'd0) begin
            t = int'($signed(it.target));
            dir_up[ph] = (t >= 0);
            loop_on = 1'b0;
            res.phase = 2'(ph);
            res.cmp = scale_to_period(t < 0 ? -t : t);
            res.neg = !dir_up[ph];
            fires = 1'b1;
          end
        end
        default: ;
      endcase
    end
  endtask

  // input driver: a new beat is offered once the current one has gone
  always @(negedge clk) begin
    stim_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = item_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, nxt.target, nxt.down, nxt.sample, nxt.phase};
        s_tuser <= nxt.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // monitor: check result beats, predict from accepted input beats
  always @(posedge clk) begin
    stim_t it;
    update_t want, res;
    bit fires;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (update_q.size() == 0) begin
          $display("%0t unexpected result beat: expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          want = update_q.pop_front();
          if (m_tdata[1:0] != want.phase) begin
            $display("%0t phase_out: expected %0d, got %0d", $time, want.phase, m_tdata[1:0]);
            errors++;
          end
          if (m_tdata[17:2] != want.cmp) begin
            $display("%0t compare_value: expected %0d, got %0d", $time, want.cmp,
                     m_tdata[17:2]);
            errors++;
          end
          if (m_tdata[18] != want.neg) begin
            $display("%0t direction_negative: expected %0d, got %0d", $time, want.neg,
                     m_tdata[18]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        it = stim_t'({s_tuser, s_tdata[1:0], s_tdata[13:2], s_tdata[14], s_tdata[30:15]});
        regulate(it, fires, res);
        if (fires) update_q.push_back(res);
      end
    end
  end

  task automatic push(input logic [1:0] kind, input logic [1:0] phase, input logic [11:0] sample,
                      input logic down, input logic [15:0] target);
    stim_t it;
    it.kind = kind;
    it.phase = phase;
    it.sample = sample;
    it.down = down;
    it.target = target;
    item_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || s_tvalid || update_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PWM_PERIOD:    per_reg = val[15:0];
      CFG_KP_GAIN:       kp_reg = val[15:0];
      CFG_KI_GAIN:       ki_reg = val[15:0];
      CFG_INTEG_LIMIT:   lim_reg = val;
      CFG_SETTLE_DELAY:  settle_reg = val[7:0];
      CFG_CALIB_SAMPLES: calib_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] period, input logic [15:0] kp,
                              input logic [15:0] ki, input logic [19:0] lim,
                              input logic [7:0] settle, input logic [15:0] calib);
    write_reg(CFG_PWM_PERIOD, 20'(period));
    write_reg(CFG_KP_GAIN, 20'(kp));
    write_reg(CFG_KI_GAIN, 20'(ki));
    write_reg(CFG_INTEG_LIMIT, lim);
    write_reg(CFG_SETTLE_DELAY, 20'(settle));
    write_reg(CFG_CALIB_SAMPLES, 20'(calib));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly sample streams behind a target, with voltage commands and ignored beats mixed in
  task automatic run_segment(input int n);
    int made, r;
    logic [1:0] kind, phase;
    logic [11:0] sample;
    logic [15:0] target;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      phase = 2'($urandom_range(NPH - 1));
      sample = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(1748 + $urandom_range(600));
      target = 16'($urandom);
      if (r < 70) begin
        kind = KIND_SAMPLE;
        made++;
      end else if (r < 81) begin
        kind = KIND_TARGET;
        if ($urandom_range(2) != 0) target = 16'($urandom_range(800)) - 16'd400;
        made++;
      end else if (r < 87) begin
        kind = KIND_VOLT;
        made++;
      end else if ($urandom_range(1) == 0) begin
        kind = KIND_NONE;
      end else begin
        kind = 2'($urandom_range(2));
        phase = 2'd3;
      end
      push(kind, phase, sample, 1'($urandom_range(1)), target);
    end
    wait_idle();
  endtask

  initial begin
    int cal_todo, r;
    per_reg = PWM_PERIOD_RST;
    kp_reg = KP_GAIN_RST;
    ki_reg = KI_GAIN_RST;
    lim_reg = INTEG_LIMIT_RST;
    settle_reg = SETTLE_DELAY_RST;
    calib_reg = CALIB_SAMPLES_RST;
    cal_remaining = CALIB_SAMPLES_RST;
    loop_on = 1'b0;
    for (int i = 0; i < NPH; i++) begin
      zero_lvl[i] = '0;
      settle_cnt[i] = SETTLE_DELAY_RST;
      integ_acc[i] = 0;
      target_cur[i] = '0;
      dir_up[i] = 1'b1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration window: voltage ignored, unused kind, phase out of range,
    // target accepted, extreme samples
    push(KIND_VOLT, 2'd0, 12'd0, 1'b0, 16'd1234);
    push(KIND_NONE, 2'd1, 12'd4095, 1'b1, 16'hFFFF);
    push(KIND_SAMPLE, 2'd3, 12'd4095, 1'b1, 16'd0);
    push(KIND_TARGET, 2'd0, 12'd0, 1'b0, 16'd100);
    push(KIND_SAMPLE, 2'd0, 12'd4095, 1'b0, 16'd0);
    push(KIND_SAMPLE, 2'd1, 12'd0, 1'b1, 16'd0);

    // the rest of the calibration run, with a little noise
    cal_todo = int'(CALIB_SAMPLES_RST) - 2;
    while (cal_todo > 0) begin
      r = $urandom_range(99);
      if (r < 96) begin
        push(KIND_SAMPLE, 2'($urandom_range(NPH - 1)),
             ($urandom_range(6) == 0) ? 12'($urandom) : 12'(1984 + $urandom_range(128)),
             1'($urandom_range(1)), 16'($urandom));
        cal_todo--;
      end else if (r < 98) begin
        push(KIND_TARGET, 2'($urandom_range(NPH - 1)), 12'($urandom), 1'($urandom_range(1)),
             16'($urandom_range(800)) - 16'd400);
      end else if (r < 99) begin
        push(KIND_VOLT, 2'($urandom_range(NPH - 1)), 12'($urandom), 1'($urandom_range(1)),
             16'($urandom));
      end else begin
        push(KIND_SAMPLE, 2'd3, 12'($urandom), 1'($urandom_range(1)), 16'($urandom));
      end
    end
    wait_idle();

    program_regs(16'd65535, 16'd256, 16'd16, 20'd32767, 8'd1, 16'd0);
    // voltage extremes, then closed loop on each phase; settle counts still hold their reset value
    push(KIND_VOLT, 2'd0, 12'd0, 1'b0, 16'h7FFF);
    push(KIND_VOLT, 2'd1, 12'd0, 1'b0, 16'h8000);
    push(KIND_VOLT, 2'd2, 12'd0, 1'b0, 16'd0);
    push(KIND_SAMPLE, 2'd0, 12'd2048, 1'b0, 16'd0);   // loop off: no effect
    push(KIND_TARGET, 2'd0, 12'd0, 1'b0, 16'h7FFF);
    push(KIND_TARGET, 2'd1, 12'd0, 1'b0, 16'h8000);
    push(KIND_TARGET, 2'd2, 12'd0, 1'b0, 16'hFFFF);
    push(KIND_SAMPLE, 2'd0, 12'd4095, 1'b1, 16'd0);   // wrong slope for phase 0
    for (int i = 0; i < 4; i++) begin
      push(KIND_SAMPLE, 2'd0, (i % 2) ? 12'd4095 : 12'd0, 1'b0, 16'd0);
      push(KIND_SAMPLE, 2'd1, (i % 2) ? 12'd0 : 12'd4095, 1'b1, 16'd0);
      push(KIND_SAMPLE, 2'd2, (i % 2) ? 12'd4095 : 12'd0, 1'b0, 16'd0);
    end
    wait_idle();

    // no idling
    program_regs(16'd1000, 16'd256, 16'd16, 20'd32767, 8'd2, 16'd1000);
    run_segment(16);
    program_regs(16'd1, 16'd65535, 16'd65535, 20'd1048575, 8'd1, 16'd65535);
    run_segment(16);

    // sender mostly idle
    send_idle_pct = 85;
    program_regs(16'd0, 16'd0, 16'd0, 20'd0, 8'd3, 16'd0);
    run_segment(16);
    program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(4096)),
                 16'($urandom_range(1024)), 20'($urandom_range(1048575)),
                 8'($urandom_range(1, 4)), 16'($urandom));
    run_segment(16);

    // receiver mostly stalling
    send_idle_pct = 0;
    recv_stall_pct = 85;
    program_regs(16'd65535, 16'd4096, 16'd65535, 20'd100, 8'd1, 16'd1);
    run_segment(16);
    program_regs(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                 20'($urandom_range(1048575)), 8'($urandom_range(1, 4)), 16'($urandom));
    run_segment(16);

    // both sides idling; zero settle delay wraps the counter, then the longest delay
    send_idle_pct = 38;
    recv_stall_pct = 38;
    program_regs(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom_range(2048)),
                 20'($urandom_range(1048575)), 8'd0, 16'($urandom));
    run_segment(16);
    program_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(4096)),
                 16'($urandom_range(256)), 20'($urandom_range(65535)), 8'd255, 16'($urandom));
    run_segment(16);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
